// File: rtl/core/bcd_pkg.sv
// Shared types and constants of the button click event detector.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package bcd_pkg;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_DOWN       = 3'd1,
      EV_UP         = 3'd2,
      EV_REPEAT     = 3'd3,
      EV_SINGLE     = 3'd4,
      EV_DOUBLE     = 3'd5,
      EV_LONG_START = 3'd6,
      EV_LONG_HOLD  = 3'd7
   } event_type;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LEVEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_LEN   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_LEN      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_LEN     = 2'd3;

   localparam logic        RESET_ACTIVE_LEVEL = 1'b0;
   localparam logic [3:0]  RESET_SETTLE_LEN   = 4'd3;
   localparam logic [15:0] RESET_GAP_LEN      = 16'd60;
   localparam logic [15:0] RESET_HOLD_LEN     = 16'd200;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        active_level;
      logic [3:0]  settle_len;
      logic [15:0] gap_len;
      logic [15:0] hold_len;
   } bcd_cfg_type;

   // One tick's worth of results: cnt items (one to three), all sharing the
   // latched event and repeat count. A status-only tick has cnt 1, fired 0.
   typedef struct packed {
      logic [1:0] cnt;
      logic       fired;
      event_type  ev0;
      event_type  ev1;
      event_type  ev2;
      event_type  latched;
      logic [3:0] repeat_count;
   } bcd_rec_type;

endpackage

`default_nettype wire

// File: rtl/core/bcd_req_if.sv
// Input channel of the button click event detector: one sampled pin level per tick.
// Stand-alone interface; no package dependency.
`default_nettype none

interface bcd_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink   (input valid, input pin_level, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bcd_rsp_if.sv
// Result channel of the button click event detector: one event or status item per transfer.
// Stand-alone interface; no package dependency.
`default_nettype none

interface bcd_rsp_if;
   logic       valid;
   logic       ready;
   logic       fired;
   logic [2:0] event_code;
   logic [2:0] latched_event;
   logic [3:0] repeat_count;
   logic       last;

   modport source (output valid, output fired, output event_code, output latched_event,
                   output repeat_count, output last, input ready);
   modport sink   (input valid, input fired, input event_code, input latched_event,
                   input repeat_count, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/button_click_event_detector.sv
// The detector takes one pin sample per tick transfer and reports button events: press down,
// press up, repeat, single click, double click, long press start and long press hold. A tick
// is accepted in every cycle while the record queue (QueueDepth entries) has room; the front
// end debounces and classifies it in that same cycle. Each tick yields one to three result
// transfers, last marked, sent one per cycle from the single output register while the
// receiver is ready. A tick's record is written into the queue and its items are then
// loaded into the output register one at a time. There is no clearing pass after reset.
// Configuration must be written only while no results are outstanding.
// Depends on bcd_pkg, bcd_req_if, bcd_rsp_if, bcd_front, bcd_queue and bcd_back.
`default_nettype none

module button_click_event_detector #(
   parameter int unsigned QueueDepth = bcd_pkg::QUEUE_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   bcd_req_if.sink                                 req_if,
   bcd_rsp_if.source                               rsp_if,
   input  wire logic                               csr_we,
   input  wire logic [bcd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bcd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bcd_pkg::*;

   bcd_cfg_type cfg_ff;
   bcd_rec_type front_rec;
   bcd_rec_type head;
   logic        push;
   logic        pop;
   logic        head_valid;
   logic        q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level <= RESET_ACTIVE_LEVEL;
         cfg_ff.settle_len   <= RESET_SETTLE_LEN;
         cfg_ff.gap_len      <= RESET_GAP_LEN;
         cfg_ff.hold_len     <= RESET_HOLD_LEN;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE_LEVEL: cfg_ff.active_level <= csr_wdata[0];
            CSR_SETTLE_LEN:   cfg_ff.settle_len   <= csr_wdata[3:0];
            CSR_GAP_LEN:      cfg_ff.gap_len      <= csr_wdata[15:0];
            CSR_HOLD_LEN:     cfg_ff.hold_len     <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   bcd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .push   (push),
      .rec    (front_rec)
   );

   bcd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (front_rec),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (q_full)
   );

   bcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire

// File: rtl/core/bcd_front.sv
// Front end: debounces each tick's pin sample, runs the click state machine and
// writes one result record per tick into the queue. Depends on bcd_pkg and bcd_req_if.
`default_nettype none

module bcd_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   bcd_req_if.sink                   req_if,
   input  wire bcd_pkg::bcd_cfg_type cfg,
   input  wire logic                 q_full,
   output logic                      push,
   output bcd_pkg::bcd_rec_type      rec
);
   import bcd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_HELD      = 3'd1,
      ST_RELEASED  = 3'd2,
      ST_REPRESSED = 3'd3,
      ST_LONG      = 3'd5
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] tick_ff, tick_in, tick_inc;
   logic [3:0]  dc_ff, dc_in, dc_inc;
   logic        stable_ff, stable_in, stable_cur;
   logic        primed_ff;
   logic [3:0]  repeat_ff, repeat_in, repeat_inc;
   event_type   latched_ff, latched_in;
   logic [1:0]  nev;
   event_type   ev0, ev1, ev2;
   logic        pressed;
   logic        pin;

   assign req_if.ready = !q_full;
   assign push         = req_if.valid && !q_full;
   assign pin          = req_if.pin_level;

   always_comb begin
      // The very first sample is taken as the debounced level outright.
      stable_cur = primed_ff ? stable_ff : pin;

      tick_inc = tick_ff;
      if (state_ff != ST_IDLE && tick_ff != 16'hFFFF) begin
         tick_inc = tick_ff + 16'd1;
      end

      dc_inc = (dc_ff != 4'hF) ? dc_ff + 4'd1 : dc_ff;
      stable_in = stable_cur;
      dc_in     = '0;
      if (pin != stable_cur) begin
         if (dc_inc >= cfg.settle_len) begin
            stable_in = pin;
         end else begin
            dc_in = dc_inc;
         end
      end

      pressed    = (stable_in == cfg.active_level);
      repeat_inc = (repeat_ff != 4'hF) ? repeat_ff + 4'd1 : repeat_ff;

      state_in   = state_ff;
      tick_in    = tick_inc;
      repeat_in  = repeat_ff;
      latched_in = latched_ff;
      nev        = 2'd0;
      ev0        = EV_NONE;
      ev1        = EV_NONE;
      ev2        = EV_NONE;

      case (state_ff)
         ST_IDLE: begin
            if (pressed) begin
               latched_in = EV_DOWN;
               ev0        = EV_DOWN;
               nev        = 2'd1;
               tick_in    = '0;
               repeat_in  = 4'd1;
               state_in   = ST_HELD;
            end else begin
               latched_in = EV_NONE;
            end
         end
         ST_HELD: begin
            if (!pressed) begin
               latched_in = EV_UP;
               ev0        = EV_UP;
               nev        = 2'd1;
               tick_in    = '0;
               state_in   = ST_RELEASED;
            end else if (tick_inc > cfg.hold_len) begin
               latched_in = EV_LONG_START;
               ev0        = EV_LONG_START;
               nev        = 2'd1;
               state_in   = ST_LONG;
            end
         end
         ST_RELEASED: begin
            if (pressed) begin
               // A re-press reports down, double on the second press, then repeat.
               latched_in = EV_DOWN;
               ev0        = EV_DOWN;
               repeat_in  = repeat_inc;
               if (repeat_inc == 4'd2) begin
                  ev1 = EV_DOUBLE;
                  ev2 = EV_REPEAT;
                  nev = 2'd3;
               end else begin
                  ev1 = EV_REPEAT;
                  nev = 2'd2;
               end
               tick_in  = '0;
               state_in = ST_REPRESSED;
            end else if (tick_inc > cfg.gap_len) begin
               // A double click is latched here but was already reported.
               if (repeat_ff == 4'd1) begin
                  latched_in = EV_SINGLE;
                  ev0        = EV_SINGLE;
                  nev        = 2'd1;
               end else if (repeat_ff == 4'd2) begin
                  latched_in = EV_DOUBLE;
               end
               state_in = ST_IDLE;
            end
         end
         ST_REPRESSED: begin
            if (!pressed) begin
               latched_in = EV_UP;
               ev0        = EV_UP;
               nev        = 2'd1;
               if (tick_inc < cfg.gap_len) begin
                  tick_in  = '0;
                  state_in = ST_RELEASED;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LONG: begin
            nev = 2'd1;
            if (pressed) begin
               latched_in = EV_LONG_HOLD;
               ev0        = EV_LONG_HOLD;
            end else begin
               latched_in = EV_UP;
               ev0        = EV_UP;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            latched_in = EV_NONE;
            state_in   = ST_IDLE;
         end
      endcase

      rec.cnt          = (nev == 2'd0) ? 2'd1 : nev;
      rec.fired        = (nev != 2'd0);
      rec.ev0          = ev0;
      rec.ev1          = ev1;
      rec.ev2          = ev2;
      rec.latched      = latched_in;
      rec.repeat_count = repeat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tick_ff    <= '0;
         dc_ff      <= '0;
         stable_ff  <= 1'b0;
         primed_ff  <= 1'b0;
         repeat_ff  <= '0;
         latched_ff <= EV_NONE;
      end else if (push) begin
         state_ff   <= state_in;
         tick_ff    <= tick_in;
         dc_ff      <= dc_in;
         stable_ff  <= stable_in;
         primed_ff  <= 1'b1;
         repeat_ff  <= repeat_in;
         latched_ff <= latched_in;
      end
   end

   // Only the idle state enters the held state, and it sets the count to one.
   a_held_single_press : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HELD) |-> (repeat_ff == 4'd1))
      else $error("held state with a press count other than one");

   // Leaving the released state by a re-press always reports at least down and repeat.
   a_repress_two_items : assert property (@(posedge clock) disable iff (reset)
      (push && state_ff == ST_RELEASED && state_in == ST_REPRESSED) |-> (rec.cnt >= 2'd2))
      else $error("re-press without repeat item");

endmodule

`default_nettype wire

// File: rtl/core/bcd_queue.sv
// Short queue of per-tick result records between front and back end.
// Depends on bcd_pkg.
`default_nettype none

module bcd_queue #(
   parameter int unsigned Depth = bcd_pkg::QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire bcd_pkg::bcd_rec_type push_rec,
   input  wire logic                 pop,
   output bcd_pkg::bcd_rec_type      head,
   output logic                      head_valid,
   output logic                      full
);
   import bcd_pkg::*;

   localparam int unsigned PtrW = $clog2(Depth);
   localparam int unsigned CntW = $clog2(Depth + 1);

   bcd_rec_type     mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign head       = mem_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CntW'(Depth));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("record taken from an empty queue");

endmodule

`default_nettype wire

// File: rtl/core/bcd_back.sv
// Back end: expands each queued record into one to three result transfers
// through a registered output stage. Depends on bcd_pkg and bcd_rsp_if.
`default_nettype none

module bcd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bcd_pkg::bcd_rec_type head,
   input  wire logic                 head_valid,
   output logic                      pop,
   bcd_rsp_if.source                 rsp_if
);
   import bcd_pkg::*;

   logic       idx_ff, idx_hi_ff;
   logic [1:0] idx;
   logic       rsp_valid_ff;
   logic       fired_ff;
   event_type  event_ff, event_in;
   event_type  latched_ff;
   logic [3:0] repeat_ff;
   logic       last_ff;
   logic       load;
   logic       final_item;

   assign idx        = {idx_hi_ff, idx_ff};
   assign load       = head_valid && (!rsp_valid_ff || rsp_if.ready);
   assign final_item = (idx == head.cnt - 2'd1);
   assign pop        = load && final_item;

   always_comb begin
      case (idx)
         2'd0:    event_in = head.ev0;
         2'd1:    event_in = head.ev1;
         default: event_in = head.ev2;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 1'b0;
         idx_hi_ff    <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pop) begin
            {idx_hi_ff, idx_ff} <= 2'd0;
         end else if (load) begin
            {idx_hi_ff, idx_ff} <= idx + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         fired_ff   <= head.fired;
         event_ff   <= event_in;
         latched_ff <= head.latched;
         repeat_ff  <= head.repeat_count;
         last_ff    <= final_item;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.fired         = fired_ff;
   assign rsp_if.event_code    = event_ff;
   assign rsp_if.latched_event = latched_ff;
   assign rsp_if.repeat_count  = repeat_ff;
   assign rsp_if.last          = last_ff;

   // Releasing a record must coincide with loading its marked final item.
   a_pop_marks_last : assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid_ff && last_ff))
      else $error("record released without a final item");

endmodule

`default_nettype wire

// File: test/tb_button_click_event_detector.sv
`timescale 1ns / 100ps
// Self-checking testbench for button_click_event_detector: pin-level ticks go in through
// bcd_req_if and every result transfer on bcd_rsp_if is checked against a tick predictor.
// Depends on bcd_pkg, bcd_req_if, bcd_rsp_if and the detector RTL.

module tb_button_click_event_detector;
   import bcd_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned RANDOM_TICKS = 240;
   localparam int unsigned PHASE_TICKS  = 34;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_HELD      = 3'd1,
      ST_RELEASED  = 3'd2,
      ST_REPRESSED = 3'd3,
      ST_LONG      = 3'd5
   } click_state_type;

   typedef struct packed {
      logic       fired;
      event_type  code;
      event_type  latched;
      logic [3:0] repeat_count;
      logic       last;
   } click_item_type;

   class click_sb;
      logic            active_lvl;
      logic [3:0]      settle_need;
      logic [15:0]     gap_limit;
      logic [15:0]     hold_limit;
      click_state_type mode;
      logic [15:0]     ticks_in_mode;
      logic [3:0]      settle_count;
      logic            stable_lvl;
      logic            primed;
      logic [3:0]      presses;
      event_type       latched;
      click_item_type  expected_items[$];
      int              errors;
      int              results;
      int              fired_by_code[8];

      function new();
         active_lvl    = RESET_ACTIVE_LEVEL;
         settle_need   = RESET_SETTLE_LEN;
         gap_limit     = RESET_GAP_LEN;
         hold_limit    = RESET_HOLD_LEN;
         mode          = ST_IDLE;
         ticks_in_mode = '0;
         settle_count  = '0;
         stable_lvl    = 1'b0;
         primed        = 1'b0;
         presses       = '0;
         latched       = EV_NONE;
         errors        = 0;
         results       = 0;
         foreach (fired_by_code[i]) fired_by_code[i] = 0;
      endfunction

      function void set_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_ACTIVE_LEVEL: active_lvl  = val[0];
            CSR_SETTLE_LEN:   settle_need = val[3:0];
            CSR_GAP_LEN:      gap_limit   = val[15:0];
            CSR_HOLD_LEN:     hold_limit  = val[15:0];
            default: ;
         endcase
      endfunction

      // Works out the events of one accepted tick and queues its result items.
      function void note_tick(input logic pin);
         event_type      fired_q[$];
         logic           pressed;
         click_item_type item;
         if (!primed) begin
            stable_lvl = pin;
            primed     = 1'b1;
         end
         if (mode != ST_IDLE && ticks_in_mode != 16'hFFFF) ticks_in_mode++;
         if (pin != stable_lvl) begin
            if (settle_count != 4'hF) settle_count++;
            if (settle_count >= settle_need) begin
               stable_lvl   = pin;
               settle_count = '0;
            end
         end else begin
            settle_count = '0;
         end
         pressed = (stable_lvl == active_lvl);

         case (mode)
            ST_IDLE: begin
               if (pressed) begin
                  latched = EV_DOWN;
                  fired_q.push_back(EV_DOWN);
                  ticks_in_mode = '0;
                  presses       = 4'd1;
                  mode          = ST_HELD;
               end else begin
                  latched = EV_NONE;
               end
            end
            ST_HELD: begin
               if (!pressed) begin
                  latched = EV_UP;
                  fired_q.push_back(EV_UP);
                  ticks_in_mode = '0;
                  mode          = ST_RELEASED;
               end else if (ticks_in_mode > hold_limit) begin
                  latched = EV_LONG_START;
                  fired_q.push_back(EV_LONG_START);
                  mode = ST_LONG;
               end
            end
            ST_RELEASED: begin
               if (pressed) begin
                  latched = EV_DOWN;
                  fired_q.push_back(EV_DOWN);
                  if (presses != 4'hF) presses++;
                  if (presses == 4'd2) fired_q.push_back(EV_DOUBLE);
                  fired_q.push_back(EV_REPEAT);
                  ticks_in_mode = '0;
                  mode          = ST_REPRESSED;
               end else if (ticks_in_mode > gap_limit) begin
                  // The gap closes the sequence; a double is latched but not reported.
                  if (presses == 4'd1) begin
                     latched = EV_SINGLE;
                     fired_q.push_back(EV_SINGLE);
                  end else if (presses == 4'd2) begin
                     latched = EV_DOUBLE;
                  end
                  mode = ST_IDLE;
               end
            end
            ST_REPRESSED: begin
               if (!pressed) begin
                  latched = EV_UP;
                  fired_q.push_back(EV_UP);
                  if (ticks_in_mode < gap_limit) begin
                     ticks_in_mode = '0;
                     mode          = ST_RELEASED;
                  end else begin
                     mode = ST_IDLE;
                  end
               end
            end
            ST_LONG: begin
               if (pressed) begin
                  latched = EV_LONG_HOLD;
                  fired_q.push_back(EV_LONG_HOLD);
               end else begin
                  latched = EV_UP;
                  fired_q.push_back(EV_UP);
                  mode = ST_IDLE;
               end
            end
            default: begin
               mode    = ST_IDLE;
               latched = EV_NONE;
            end
         endcase

         item.latched      = latched;
         item.repeat_count = presses;
         if (fired_q.size() == 0) begin
            item.fired = 1'b0;
            item.code  = EV_NONE;
            item.last  = 1'b1;
            expected_items.push_back(item);
         end else begin
            foreach (fired_q[k]) begin
               item.fired = 1'b1;
               item.code  = fired_q[k];
               item.last  = (k == fired_q.size() - 1);
               expected_items.push_back(item);
            end
         end
      endfunction

      function void check_item(input click_item_type got);
         click_item_type want;
         results++;
         if (expected_items.size() == 0) begin
            errors++;
            $error("result transfer with nothing expected: fired %0d event_code %0d",
                   got.fired, got.code);
            return;
         end
         want = expected_items.pop_front();
         if (got.fired !== want.fired) begin
            errors++;
            $error("fired: expected %0d, got %0d", want.fired, got.fired);
         end
         if (got.code !== want.code) begin
            errors++;
            $error("event_code: expected %0d, got %0d", want.code, got.code);
         end
         if (got.latched !== want.latched) begin
            errors++;
            $error("latched_event: expected %0d, got %0d", want.latched, got.latched);
         end
         if (got.repeat_count !== want.repeat_count) begin
            errors++;
            $error("repeat_count: expected %0d, got %0d", want.repeat_count, got.repeat_count);
         end
         if (got.last !== want.last) begin
            errors++;
            $error("last: expected %0d, got %0d", want.last, got.last);
         end
         if (want.fired) fired_by_code[want.code]++;
      endfunction

      function int outstanding();
         return expected_items.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bit          tx_burst;
   bit          rx_burst;
   bit          drain_next;
   int          rx_hold;
   int unsigned cycles = 0;
   int unsigned ticks_sent = 0;
   int unsigned phases_run = 0;

   // Current register values, kept only to shape the stimulus.
   logic        cfg_act;
   logic [3:0]  cfg_deb;
   logic [15:0] cfg_gap;
   logic [15:0] cfg_hold;

   click_sb sb = new();

   bcd_req_if req();
   bcd_rsp_if rsp();

   button_click_event_detector DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Result side: check each transfer, then decide the next cycle's ready.
   always @(posedge clock) begin
      click_item_type got;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.fired        = rsp.fired;
            got.code         = event_type'(rsp.event_code);
            got.latched      = event_type'(rsp.latched_event);
            got.repeat_count = rsp.repeat_count;
            got.last         = rsp.last;
            sb.check_item(got);
         end
         if (rx_hold > 0) begin
            rsp.ready <= 1'b0;
            rx_hold--;
         end else begin
            rsp.ready <= 1'b1;
            if (!rx_burst && $urandom_range(0, 2) == 0) rx_hold = idle_gap();
         end
      end
   end

   task automatic send_tick(input logic pin);
      int gap;
      gap = tx_burst ? 0 : idle_gap();
      if (drain_next) begin
         // Hold the sender off until every result of earlier ticks has been taken.
         drain_next = 1'b0;
         req.valid <= 1'b0;
         do @(posedge clock); while (sb.outstanding() != 0);
      end else if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.pin_level <= pin;
      do @(posedge clock); while (req.ready !== 1'b1);
      sb.note_tick(pin);
      ticks_sent++;
   endtask

   task automatic send_run(input logic lvl, input int count, input bit glitchy);
      logic pin;
      for (int i = 0; i < count; i++) begin
         pin = lvl;
         if (glitchy && $urandom_range(0, 24) == 0) pin = ~lvl;
         send_tick(pin);
      end
   endtask

   // One click sequence: short inner gaps, and a closing gap past any limit up to 16.
   task automatic send_clicks(input int clicks);
      int need;
      int press_len;
      int release_len;
      bit glitchy;
      need    = (cfg_deb == 4'd0) ? 1 : int'(cfg_deb);
      glitchy = (cfg_deb >= 4'd2);
      for (int c = 0; c < clicks; c++) begin
         press_len = need + $urandom_range(0, 2);
         if (c == 0 && clicks < 3 && cfg_hold <= 16'd16 && $urandom_range(0, 2) == 0)
            press_len = need + int'(cfg_hold) + $urandom_range(1, 3);
         send_run(cfg_act, press_len, glitchy);
         if (c == clicks - 1)
            release_len = need + ((cfg_gap <= 16'd16) ?
                                  int'(cfg_gap) + $urandom_range(1, 3) :
                                  $urandom_range(0, 4));
         else
            release_len = need + ((cfg_gap <= 16'd8) ?
                                  $urandom_range(0, int'(cfg_gap) - 1) :
                                  $urandom_range(0, 3));
         send_run(~cfg_act, release_len, glitchy);
      end
   endtask

   // Drops valid and waits until the block has nothing left to send.
   task automatic settle_block();
      req.valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_register(idx, val);
   endtask

   task automatic load_config(input logic act, input logic [3:0] deb,
                              input logic [15:0] gap, input logic [15:0] hold);
      write_reg(CSR_ACTIVE_LEVEL, CSR_DATA_W'(act));
      write_reg(CSR_SETTLE_LEN, CSR_DATA_W'(deb));
      write_reg(CSR_GAP_LEN, gap);
      write_reg(CSR_HOLD_LEN, hold);
      csr_we   <= 1'b0;
      cfg_act  = act;
      cfg_deb  = deb;
      cfg_gap  = gap;
      cfg_hold = hold;
      phases_run++;
   endtask

   initial begin
      logic [0:18] opening;
      int unsigned rand_start;
      int unsigned phase_start;
      int          phase;
      int          clicks;
      bit          pressure_done;
      logic        act;
      logic [3:0]  deb;
      logic [15:0] gap;
      logic [15:0] hold;

      reset         = 1'b1;
      req.valid     = 1'b0;
      req.pin_level = 1'b0;
      rsp.ready     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      tx_burst      = 1'b0;
      rx_burst      = 1'b0;
      drain_next    = 1'b0;
      rx_hold       = 0;
      pressure_done = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Opening sequence with no debounce delay: a pressed first sample, a long press
      // with hold, a double click that expires, then a single click.
      opening = 19'b1111110_1010000_10000;
      load_config(1'b1, 4'd0, 16'd2, 16'd3);
      for (int i = 0; i < 19; i++) begin
         // Part way through, the sender waits for every result so far.
         if (i == 10) drain_next = 1'b1;
         send_tick(opening[i]);
      end

      rand_start = ticks_sent;
      phase      = 0;
      while (ticks_sent - rand_start < RANDOM_TICKS) begin
         act = 1'($urandom_range(0, 1));
         case (phase)
            0: begin deb = 4'd0;  gap = 16'hFFFF; hold = 16'd1;    end
            1: begin deb = 4'd15; gap = 16'd1;    hold = 16'hFFFF; end
            2: begin
               act  = RESET_ACTIVE_LEVEL;
               deb  = RESET_SETTLE_LEN;
               gap  = RESET_GAP_LEN;
               hold = RESET_HOLD_LEN;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0:       deb = 4'd1;
                  1:       deb = 4'd0;
                  default: deb = 4'($urandom_range(1, 4));
               endcase
               case ($urandom_range(0, 3))
                  0:       gap = 16'd1;
                  1:       gap = 16'hFFFF;
                  default: gap = 16'($urandom_range(2, 10));
               endcase
               case ($urandom_range(0, 3))
                  0:       hold = 16'd1;
                  1:       hold = 16'hFFFF;
                  default: hold = 16'($urandom_range(2, 16));
               endcase
            end
         endcase
         settle_block();
         load_config(act, deb, gap, hold);
         tx_burst    = ($urandom_range(0, 3) == 0);
         rx_burst    = ($urandom_range(0, 3) == 0);
         phase_start = ticks_sent;
         while (ticks_sent - phase_start < PHASE_TICKS &&
                ticks_sent - rand_start < RANDOM_TICKS) begin
            if (phase == 3 && !pressure_done && ticks_sent - phase_start >= 10) begin
               drain_next    = 1'b1;
               pressure_done = 1'b1;
            end
            if (phase != 0 && $urandom_range(0, 6) == 0) begin
               repeat ($urandom_range(1, 4)) send_tick(1'($urandom_range(0, 1)));
            end else begin
               if (phase == 0)
                  clicks = 18;
               else if ($urandom_range(0, 4) == 0)
                  clicks = $urandom_range(3, 6);
               else
                  clicks = $urandom_range(1, 2);
               send_clicks(clicks);
            end
         end
         phase++;
      end

      settle_block();
      $display("Checked %0d result transfers from %0d ticks over %0d register settings.",
               sb.results, ticks_sent, phases_run);
      $display("Fired: down %0d, up %0d, repeat %0d, single %0d, double %0d, long %0d/%0d.",
               sb.fired_by_code[EV_DOWN], sb.fired_by_code[EV_UP],
               sb.fired_by_code[EV_REPEAT], sb.fired_by_code[EV_SINGLE],
               sb.fired_by_code[EV_DOUBLE], sb.fired_by_code[EV_LONG_START],
               sb.fired_by_code[EV_LONG_HOLD]);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
